// ----- rtl/fccg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccg_pkg
// Shared widths, register map and types of the four-corner colour gradient.
// ----------------------------------------------------------------------------
package fccg_pkg;

  // frame size limit and field widths
  localparam int MAX_SIZE_LOG2 = 12;
  localparam int LOG_W         = 4;
  localparam int COORD_W       = 12;
  localparam int SIZE_W        = MAX_SIZE_LOG2 + 1;
  localparam int WEIGHT_W      = 2 * MAX_SIZE_LOG2 + 1;
  localparam int CH_W          = 8;
  localparam int N_CH          = 4;
  localparam int N_CORNER      = 4;
  localparam int CORNER_W      = CH_W * N_CH;
  localparam int ACC_W         = CH_W + 2 * MAX_SIZE_LOG2;
  localparam int SHAMT_W       = $clog2(2 * MAX_SIZE_LOG2 + 1);

  // output queue
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  // register file
  localparam int DATA_W        = 32;
  localparam int PADDR_W       = 5;
  localparam int RIDX_W        = 3;

  localparam logic [LOG_W-1:0] LOG_RESET = LOG_W'(8);

  typedef enum logic [RIDX_W-1:0] {
    REG_WIDTH_LOG2    = 3'd0,
    REG_HEIGHT_LOG2   = 3'd1,
    REG_CORNER_TL     = 3'd2,
    REG_CORNER_TR     = 3'd3,
    REG_CORNER_BL     = 3'd4,
    REG_CORNER_BR     = 3'd5
  } reg_idx_t;

  // corner order: top left, top right, bottom left, bottom right
  typedef struct packed {
    logic [LOG_W-1:0]                       width_log2;
    logic [LOG_W-1:0]                       height_log2;
    logic [N_CORNER-1:0][CORNER_W-1:0]      corner;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;
    logic            outside_frame;
  } pix_t;

  function automatic logic [LOG_W-1:0] clamp_log(input logic [LOG_W-1:0] v);
    logic [LOG_W-1:0] r;
    r = (v > LOG_W'(MAX_SIZE_LOG2)) ? LOG_W'(MAX_SIZE_LOG2) : v;
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fccg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccg channel interfaces
// Coordinate word in, colour word out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface fccg_coord_if;
  logic                          valid;
  logic                          ready;
  logic [fccg_pkg::COORD_W-1:0]  pixel_x;
  logic [fccg_pkg::COORD_W-1:0]  pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface fccg_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [fccg_pkg::CH_W-1:0]  red;
  logic [fccg_pkg::CH_W-1:0]  green;
  logic [fccg_pkg::CH_W-1:0]  blue;
  logic [fccg_pkg::CH_W-1:0]  alpha;
  logic                       outside_frame;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output outside_frame, input ready);
  modport sink   (input valid, input red, input green, input blue, input alpha,
                  input outside_frame, output ready);
endinterface
`default_nettype wire

// ----- rtl/fccg_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccg_datapath
// Free-running four-stage interpolation pipeline plus final sum and shift.
// ----------------------------------------------------------------------------
module fccg_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire fccg_pkg::cfg_t                  cfg,
  input  wire logic                            in_valid,
  input  wire logic [fccg_pkg::COORD_W-1:0]    in_x,
  input  wire logic [fccg_pkg::COORD_W-1:0]    in_y,
  output fccg_pkg::pix_t                       res,
  output logic                                 res_valid
);

  // clamped frame size
  logic [fccg_pkg::LOG_W-1:0]    wl, hl;
  logic [fccg_pkg::SIZE_W-1:0]   w, h;

  assign wl = fccg_pkg::clamp_log(cfg.width_log2);
  assign hl = fccg_pkg::clamp_log(cfg.height_log2);
  assign w  = fccg_pkg::SIZE_W'(1) << wl;
  assign h  = fccg_pkg::SIZE_W'(1) << hl;

  // stage 1: distances to far edges, frame check
  logic                            s1_vld;
  logic [fccg_pkg::COORD_W-1:0]    s1_x, s1_y;
  logic [fccg_pkg::SIZE_W-1:0]     s1_wx, s1_hy;
  logic                            s1_out;
  logic [fccg_pkg::SHAMT_W-1:0]    s1_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= in_valid;
    end
    s1_x   <= in_x;
    s1_y   <= in_y;
    s1_wx  <= w - fccg_pkg::SIZE_W'(in_x);
    s1_hy  <= h - fccg_pkg::SIZE_W'(in_y);
    s1_out <= (fccg_pkg::SIZE_W'(in_x) >= w) || (fccg_pkg::SIZE_W'(in_y) >= h);
    s1_sh  <= fccg_pkg::SHAMT_W'(wl) + fccg_pkg::SHAMT_W'(hl);
  end

  // stage 2: corner weights, operands widened so the full product is kept
  logic                                            s2_vld;
  logic [fccg_pkg::N_CORNER-1:0][fccg_pkg::WEIGHT_W-1:0] s2_wt;
  logic                                            s2_out;
  logic [fccg_pkg::SHAMT_W-1:0]                    s2_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
    s2_wt[0] <= fccg_pkg::WEIGHT_W'(s1_wx) * fccg_pkg::WEIGHT_W'(s1_hy);
    s2_wt[1] <= fccg_pkg::WEIGHT_W'(s1_x) * fccg_pkg::WEIGHT_W'(s1_hy);
    s2_wt[2] <= fccg_pkg::WEIGHT_W'(s1_wx) * fccg_pkg::WEIGHT_W'(s1_y);
    s2_wt[3] <= fccg_pkg::WEIGHT_W'(s1_x) * fccg_pkg::WEIGHT_W'(s1_y);
    s2_out   <= s1_out;
    s2_sh    <= s1_sh;
  end

  // stage 3: channel times weight, one product per corner and channel
  logic                                            s3_vld;
  logic [fccg_pkg::N_CH-1:0][fccg_pkg::N_CORNER-1:0][fccg_pkg::ACC_W-1:0] s3_prod;
  logic                                            s3_out;
  logic [fccg_pkg::SHAMT_W-1:0]                    s3_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
    for (int c = 0; c < fccg_pkg::N_CH; c++) begin
      for (int k = 0; k < fccg_pkg::N_CORNER; k++) begin
        s3_prod[c][k] <= fccg_pkg::ACC_W'(cfg.corner[k][c*fccg_pkg::CH_W +: fccg_pkg::CH_W])
                         * fccg_pkg::ACC_W'(s2_wt[k]);
      end
    end
    s3_out <= s2_out;
    s3_sh  <= s2_sh;
  end

  // stage 4: pair sums (top pair, bottom pair)
  logic                                            s4_vld;
  logic [fccg_pkg::N_CH-1:0][fccg_pkg::ACC_W-1:0]  s4_top, s4_bot;
  logic                                            s4_out;
  logic [fccg_pkg::SHAMT_W-1:0]                    s4_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
    for (int c = 0; c < fccg_pkg::N_CH; c++) begin
      s4_top[c] <= s3_prod[c][0] + s3_prod[c][1];
      s4_bot[c] <= s3_prod[c][2] + s3_prod[c][3];
    end
    s4_out <= s3_out;
    s4_sh  <= s3_sh;
  end

  // final sum, exact divide by frame area, blank outside the frame
  logic [fccg_pkg::N_CH-1:0][fccg_pkg::ACC_W-1:0]  acc;
  logic [fccg_pkg::N_CH-1:0][fccg_pkg::CH_W-1:0]   chan;

  always_comb begin
    for (int c = 0; c < fccg_pkg::N_CH; c++) begin
      acc[c]  = s4_top[c] + s4_bot[c];
      chan[c] = s4_out ? '0 : fccg_pkg::CH_W'(acc[c] >> s4_sh);
    end
  end

  assign res_valid         = s4_vld;
  assign res.red           = chan[0];
  assign res.green         = chan[1];
  assign res.blue          = chan[2];
  assign res.alpha         = chan[3];
  assign res.outside_frame = s4_out;

endmodule
`default_nettype wire

// ----- rtl/fccg_out_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccg_out_fifo
// Result queue between the free-running pipeline and the output channel.
// ----------------------------------------------------------------------------
module fccg_out_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire fccg_pkg::pix_t  push_data,
  input  wire logic            pop,
  output fccg_pkg::pix_t       head,
  output logic                 not_empty
);

  fccg_pkg::pix_t                 mem [fccg_pkg::FIFO_DEPTH];
  logic [fccg_pkg::FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [fccg_pkg::FIFO_CW-1:0]   count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill; push never meets a full queue (credit held upstream)
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + fccg_pkg::FIFO_CW'(push) - fccg_pkg::FIFO_CW'(pop);
    end
  end

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

endmodule
`default_nettype wire

// ----- rtl/four_corner_color_gradient.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_corner_color_gradient
// Bilinear RGBA gradient between four corner colours over a 2^n frame.
// Path: an accepted coordinate passes the 4 pipeline stages, then the
//   output queue, before its result is valid.
// Throughput: one pixel per cycle; up to 8 words in flight, set by the
//   output queue depth, before a stalled output holds off the input.
// Reset (rst, synchronous): empties pipeline and queue, sizes back to 256,
//   corners to zero.
// ----------------------------------------------------------------------------
module four_corner_color_gradient (
  input  wire logic                            clk,
  input  wire logic                            rst,
  fccg_coord_if.sink                           coord,
  fccg_pixel_if.source                         pixel,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fccg_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [fccg_pkg::DATA_W-1:0]     pwdata,
  output logic [fccg_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);

  fccg_pkg::cfg_t                  cfg;
  logic                            wr_en;
  logic [fccg_pkg::RIDX_W-1:0]     ridx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = paddr[fccg_pkg::PADDR_W-1:2];

  // register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_log2  <= fccg_pkg::LOG_RESET;
      cfg.height_log2 <= fccg_pkg::LOG_RESET;
      cfg.corner      <= '0;
    end else if (wr_en) begin
      unique case (ridx)
        fccg_pkg::REG_WIDTH_LOG2:  cfg.width_log2  <= pwdata[fccg_pkg::LOG_W-1:0];
        fccg_pkg::REG_HEIGHT_LOG2: cfg.height_log2 <= pwdata[fccg_pkg::LOG_W-1:0];
        fccg_pkg::REG_CORNER_TL:   cfg.corner[0]   <= pwdata;
        fccg_pkg::REG_CORNER_TR:   cfg.corner[1]   <= pwdata;
        fccg_pkg::REG_CORNER_BL:   cfg.corner[2]   <= pwdata;
        fccg_pkg::REG_CORNER_BR:   cfg.corner[3]   <= pwdata;
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    unique case (ridx)
      fccg_pkg::REG_WIDTH_LOG2:  prdata = fccg_pkg::DATA_W'(cfg.width_log2);
      fccg_pkg::REG_HEIGHT_LOG2: prdata = fccg_pkg::DATA_W'(cfg.height_log2);
      fccg_pkg::REG_CORNER_TL:   prdata = cfg.corner[0];
      fccg_pkg::REG_CORNER_TR:   prdata = cfg.corner[1];
      fccg_pkg::REG_CORNER_BL:   prdata = cfg.corner[2];
      fccg_pkg::REG_CORNER_BR:   prdata = cfg.corner[3];
      default:                   prdata = '0;
    endcase
  end

  // credit count: words accepted but not yet taken at the output
  logic [fccg_pkg::FIFO_CW-1:0]  inflight;
  logic                          in_acc, out_acc;

  assign coord.ready = (inflight != fccg_pkg::FIFO_CW'(fccg_pkg::FIFO_DEPTH));
  assign in_acc      = coord.valid && coord.ready;
  assign out_acc     = pixel.valid && pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + fccg_pkg::FIFO_CW'(in_acc) - fccg_pkg::FIFO_CW'(out_acc);
    end
  end

  // interpolation pipeline
  fccg_pkg::pix_t  res, head;
  logic            res_valid;

  fccg_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_acc),
    .in_x      (coord.pixel_x),
    .in_y      (coord.pixel_y),
    .res       (res),
    .res_valid (res_valid)
  );

  // output queue
  fccg_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (out_acc),
    .head      (head),
    .not_empty (pixel.valid)
  );

  assign pixel.red           = head.red;
  assign pixel.green         = head.green;
  assign pixel.blue          = head.blue;
  assign pixel.alpha         = head.alpha;
  assign pixel.outside_frame = head.outside_frame;

endmodule
`default_nettype wire

// ----- rtl/fccg_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fccg_checker
// Port-level checks on the gradient block, bound to the top level.
// ----------------------------------------------------------------------------
module fccg_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_ready,
  input  wire logic                         out_valid,
  input  wire logic                         out_ready,
  input  wire logic [fccg_pkg::CH_W-1:0]    red,
  input  wire logic [fccg_pkg::CH_W-1:0]    green,
  input  wire logic [fccg_pkg::CH_W-1:0]    blue,
  input  wire logic [fccg_pkg::CH_W-1:0]    alpha,
  input  wire logic                         outside_frame
);

  // a stalled word stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped while stalled");

  // a stalled word keeps its payload
  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable({red, green, blue, alpha, outside_frame}))
    else $error("output word changed while stalled");

  // pixels outside the frame are blank
  a_outside_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && outside_frame |-> (red == '0) && (green == '0) && (blue == '0)
                                    && (alpha == '0))
    else $error("outside pixel carries colour");

  // reset empties the block and opens the input
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not empty after reset");

endmodule

bind four_corner_color_gradient fccg_checker u_fccg_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (coord.ready),
  .out_valid     (pixel.valid),
  .out_ready     (pixel.ready),
  .red           (pixel.red),
  .green         (pixel.green),
  .blue          (pixel.blue),
  .alpha         (pixel.alpha),
  .outside_frame (pixel.outside_frame)
);
`default_nettype wire
